### sv/fir9_pkg.sv
// Shared types and constants for the nine-tap FIR filter with three truncation variants.
package fir9_pkg;

    localparam int TAPS     = 9;
    localparam int SAMPLE_W = 11;
    localparam int TERM_W   = 8;
    localparam int ACC_W    = 12;
    localparam int OUT_W    = 12;
    localparam int COEF_W   = 10;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [TERM_W-1:0]   term_t;
    typedef logic signed [ACC_W-1:0]    acc_t;
    typedef logic signed [OUT_W-1:0]    result_t;
    typedef logic signed [COEF_W-1:0]   coef_t;

    // Truncated products of one tap, one per variant.
    typedef struct packed {
        term_t t8;
        term_t t7;
        term_t tf;
    } terms_t;

    // Symmetric filter coefficients, tap 0 applies to the newest sample.
    localparam coef_t COEF [TAPS] = '{
        -10'sd7, -10'sd14, 10'sd52, 10'sd272, 10'sd415,
        10'sd272, 10'sd52, -10'sd14, -10'sd7
    };

endpackage

### sv/fir9_window.sv
// Sample history and the registered nine-sample window of the filter.
module fir9_window (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    input  fir9_pkg::sample_t   in_sample,
    input  logic                en,
    output logic                out_valid,
    output fir9_pkg::sample_t   out_win [fir9_pkg::TAPS]
);

    fir9_pkg::sample_t hist_reg [fir9_pkg::TAPS-1];
    fir9_pkg::sample_t win_reg  [fir9_pkg::TAPS];
    logic              valid_reg;

    // The history shifts only when an item is accepted.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < fir9_pkg::TAPS - 1; k++) begin
                hist_reg[k] <= '0;
            end
        end else if (in_valid && en) begin
            hist_reg[0] <= in_sample;
            for (int k = 1; k < fir9_pkg::TAPS - 1; k++) begin
                hist_reg[k] <= hist_reg[k-1];
            end
        end
    end

    // Window stage: the new sample followed by the eight older ones.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            win_reg[0] <= in_sample;
            for (int k = 1; k < fir9_pkg::TAPS; k++) begin
                win_reg[k] <= hist_reg[k-1];
            end
        end
    end

    assign out_valid = valid_reg;
    assign out_win   = win_reg;

endmodule

### sv/fir9_products.sv
// Per-tap products and their truncation for the three variants, registered.
module fir9_products (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    input  fir9_pkg::sample_t   in_win [fir9_pkg::TAPS],
    input  logic                en,
    output logic                out_valid,
    output fir9_pkg::terms_t    out_terms [fir9_pkg::TAPS]
);

    logic signed [7:0]  sr      [fir9_pkg::TAPS];
    logic signed [6:0]  csr     [fir9_pkg::TAPS];
    logic signed [14:0] p8      [fir9_pkg::TAPS];
    logic signed [20:0] pf      [fir9_pkg::TAPS];
    fir9_pkg::terms_t   terms_next [fir9_pkg::TAPS];
    fir9_pkg::terms_t   terms_reg  [fir9_pkg::TAPS];
    logic               valid_reg;

    // Coarse operands are the sample and coefficient floored by eight.
    always_comb begin
        for (int k = 0; k < fir9_pkg::TAPS; k++) begin
            sr[k]  = 8'(in_win[k] >>> 3);
            csr[k] = 7'(fir9_pkg::COEF[k] >>> 3);
            p8[k]  = 15'(sr[k]) * 15'(csr[k]);
            pf[k]  = 21'(in_win[k]) * 21'(fir9_pkg::COEF[k]);
            terms_next[k].t8 = 8'(p8[k] >>> 7);
            terms_next[k].t7 = 8'(p8[k] >>> 8);
            terms_next[k].tf = 8'(pf[k] >>> 13);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            terms_reg <= terms_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_terms = terms_reg;

endmodule

### sv/fir9_sum.sv
// Sums the truncated terms, applies the final scaling and holds the result item.
module fir9_sum (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    input  fir9_pkg::terms_t    in_terms [fir9_pkg::TAPS],
    input  logic                en,
    output logic                out_valid,
    output logic [39:0]         out_data
);

    fir9_pkg::acc_t    acc8;
    fir9_pkg::acc_t    acc7;
    fir9_pkg::acc_t    accf;
    fir9_pkg::result_t res8;
    fir9_pkg::result_t res7;
    fir9_pkg::result_t resf;
    logic [39:0]       data_reg;
    logic              valid_reg;

    // Nine narrow terms per variant; the wrap at twelve bits is intended.
    always_comb begin
        acc8 = '0;
        acc7 = '0;
        accf = '0;
        for (int k = 0; k < fir9_pkg::TAPS; k++) begin
            acc8 = acc8 + 12'(in_terms[k].t8);
            acc7 = acc7 + 12'(in_terms[k].t7);
            accf = accf + 12'(in_terms[k].tf);
        end
        res8 = {acc8[8:0], 3'b000};
        res7 = {acc7[7:0], 4'b0000};
        resf = {accf[8:0], 3'b000};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= {4'b0000, resf, res7, res8};
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### sv/fir9_three_truncation_variants_top.sv
// Top level of the nine-tap FIR filter with three truncation variants.
//
// One signed 11-bit sample enters per item on the s_ channel and one result
// item leaves on the m_ channel carrying three 12-bit filter outputs, one for
// each truncation of the products. The filter keeps the last eight samples.
// An accepted sample passes the window register, the product register and the
// result register in that order before its result is shown with m_tvalid high.
// Throughput: one item per clock while m_tready is high, set by the
// three-stage pipeline that moves one item through each stage per cycle.
// Each stage advances when the stage after it is empty or moving, so a stalled
// receiver holds the result in place while earlier stages keep filling; input
// is refused only when all three stages hold items and m_tready is low.
// Reset (aresetn low at a rising edge) clears the sample history to zero and
// empties the pipeline; no result is pending afterward.
module fir9_three_truncation_variants_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [10:0] sample, [15:11] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [11:0] out_trunc8, [23:12] out_trunc7,
                                   // [35:24] out_full, [39:36] zero
);

    fir9_pkg::sample_t win   [fir9_pkg::TAPS];
    fir9_pkg::terms_t  terms [fir9_pkg::TAPS];
    logic              win_valid;
    logic              prod_valid;
    logic              en_win;
    logic              en_prod;
    logic              en_out;

    // Each stage may load when its successor is empty or being drained.
    assign en_out   = !m_tvalid || m_tready;
    assign en_prod  = !prod_valid || en_out;
    assign en_win   = !win_valid || en_prod;
    assign s_tready = en_win;

    fir9_window u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_sample (s_tdata[10:0]),
        .en        (en_win),
        .out_valid (win_valid),
        .out_win   (win)
    );

    fir9_products u_products (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (win_valid),
        .in_win    (win),
        .en        (en_prod),
        .out_valid (prod_valid),
        .out_terms (terms)
    );

    fir9_sum u_sum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (prod_valid),
        .in_terms  (terms),
        .en        (en_out),
        .out_valid (m_tvalid),
        .out_data  (m_tdata)
    );

`ifndef NO_ASSERTIONS
    // Input is refused only when the whole pipeline is full and blocked.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready && win_valid && prod_valid))
        else $error("input stalled while the pipeline had room");

    // Reset empties the pipeline.
    assert property (@(posedge aclk)
        !aresetn |=> (!m_tvalid && !win_valid && !prod_valid))
        else $error("pipeline not empty after reset");
`endif

endmodule

### tb/sv/fir9_three_truncation_variants_top_tb.sv
// Self-checking testbench for the nine-tap FIR filter with three truncation variants.
`timescale 1ns / 1ps

module fir9_three_truncation_variants_top_tb;

    localparam int NUM_RANDOM   = 500;
    localparam int HISTORY      = 8;
    localparam int MAX_IDLE     = 19;
    localparam int DRAIN_CYCLES = 12;

    // Filter coefficients, tap 0 weights the newest sample.
    localparam int FIR_COEF [9] = '{-7, -14, 52, 272, 415, 272, 52, -14, -7};

    // The three filter outputs of one result item.
    typedef struct {
        logic [fir9_pkg::OUT_W-1:0] trunc8;
        logic [fir9_pkg::OUT_W-1:0] trunc7;
        logic [fir9_pkg::OUT_W-1:0] full;
    } fir_outs_t;

    // Predicts the filter outputs and checks them in order of arrival.
    class fir_scoreboard;
        int        history [HISTORY];
        fir_outs_t expected_q [$];
        int        errors;
        int        checked;

        function new();
            foreach (history[i]) history[i] = 0;
            errors  = 0;
            checked = 0;
        endfunction

        // Computes the outputs for one accepted sample and shifts the history.
        function void note_sample(logic [15:0] word);
            fir9_pkg::sample_t smp;
            int        taps [9];
            int        acc8;
            int        acc7;
            int        accf;
            int        prod;
            fir_outs_t outs;
            smp     = word[fir9_pkg::SAMPLE_W-1:0];
            taps[0] = smp;
            for (int k = 1; k < 9; k++) taps[k] = history[k-1];
            acc8 = 0;
            acc7 = 0;
            accf = 0;
            for (int k = 0; k < 9; k++) begin
                prod = (taps[k] >>> 3) * (FIR_COEF[k] >>> 3);
                acc8 += prod >>> 7;
                acc7 += prod >>> 8;
                accf += (taps[k] * FIR_COEF[k]) >>> 13;
            end
            acc8 = acc8 * 8;
            acc7 = acc7 * 16;
            accf = accf * 8;
            for (int k = HISTORY - 1; k > 0; k--) history[k] = history[k-1];
            history[0]  = taps[0];
            outs.trunc8 = acc8[fir9_pkg::OUT_W-1:0];
            outs.trunc7 = acc7[fir9_pkg::OUT_W-1:0];
            outs.full   = accf[fir9_pkg::OUT_W-1:0];
            expected_q.push_back(outs);
        endfunction

        // Compares one result item with the oldest prediction.
        function void check_result(logic [39:0] word);
            fir_outs_t want;
            fir_outs_t got;
            got.trunc8 = word[11:0];
            got.trunc7 = word[23:12];
            got.full   = word[35:24];
            checked++;
            if (expected_q.size() == 0) begin
                $error("result item with no sample pending: tdata %h", word);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.trunc8 !== want.trunc8) begin
                $error("out_trunc8 mismatch: expected %0d, got %0d",
                       $signed(want.trunc8), $signed(got.trunc8));
                errors++;
            end
            if (got.trunc7 !== want.trunc7) begin
                $error("out_trunc7 mismatch: expected %0d, got %0d",
                       $signed(want.trunc7), $signed(got.trunc7));
                errors++;
            end
            if (got.full !== want.full) begin
                $error("out_full mismatch: expected %0d, got %0d",
                       $signed(want.full), $signed(got.full));
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;

    // Idle switches, changed between phases of the run.
    bit src_idle_on;
    bit sink_idle_on;

    int            samples_sent;
    fir_scoreboard sb = new();

    fir9_three_truncation_variants_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Both channels are observed at the rising edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_sample(s_tdata);
            if (m_tvalid && m_tready) sb.check_result(m_tdata);
        end
    end

    // Offers one sample, after a random gap when source idling is on, and holds it until it is taken.
    task automatic send_sample(input logic [15:0] word);
        int gap;
        gap = src_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        samples_sent++;
    endtask

    // Mostly plain samples, some with junk in the unused upper bits,
    // some at the extremes and some near zero.
    function automatic logic [15:0] random_word();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60) return {5'b0, 11'($urandom)};
        if (pick < 80) return 16'($urandom);
        if (pick < 90) return {5'b0, (pick % 2 == 1) ? 11'h3FF : 11'h400};
        return {5'b0, 11'($urandom_range(0, 15) - 8)};
    endfunction

    // Result side: random stalls before each item is taken when sink idling is on.
    initial begin
        int gap;
        wait (aresetn === 1'b1);
        forever begin
            gap = sink_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    // Stimulus and end of run.
    initial begin
        logic [15:0] directed_q [$];
        int          n_directed;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        m_tready     = 1'b0;
        samples_sent = 0;
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b1;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Impulse at full scale walks through every coefficient.
        directed_q.push_back(16'h03FF);
        repeat (8) directed_q.push_back(16'h0000);
        // Most negative sample held long enough to fill the whole window.
        repeat (9) directed_q.push_back(16'h0400);
        // Alternating extremes.
        repeat (2) begin
            directed_q.push_back(16'h03FF);
            directed_q.push_back(16'h0400);
        end
        // Minus one, one and zero, with the unused upper bits nonzero.
        directed_q.push_back(16'hFFFF);
        directed_q.push_back(16'hF801);
        directed_q.push_back(16'hA800);
        n_directed = directed_q.size();
        foreach (directed_q[i]) send_sample(directed_q[i]);

        // Random samples in five phases with varying idling on each side.
        for (int ph = 0; ph < 5; ph++) begin
            src_idle_on  = (ph == 0) || (ph == 2) || (ph == 4);
            sink_idle_on = (ph == 0) || (ph == 3) || (ph == 4);
            repeat (NUM_RANDOM / 5) send_sample(random_word());
        end
        s_tvalid <= 1'b0;

        // Drain the pipeline, then allow time for any stray result.
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d samples (%0d directed, rest random incl. upper-bit junk).",
                 samples_sent, n_directed);
        $display("Checked %0d result items with idle gaps on both channels.", sb.checked);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

### filelist.f
sv/fir9_pkg.sv
sv/fir9_window.sv
sv/fir9_products.sv
sv/fir9_sum.sv
sv/fir9_three_truncation_variants_top.sv
tb/sv/fir9_three_truncation_variants_top_tb.sv
